// File: sv/optrk_pkg.sv
// Shared definitions for the outstanding packet identifier tracker.
// Holds default sizes, request codes and the result status type.
// No dependencies.
package optrk_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 16;
	localparam int unsigned ID_WIDTH_DEF    = 16;

	// Width of the remaining-count result field.
	localparam int unsigned REM_W = 5;

	// Request codes carried on req_type.
	localparam logic [1:0] REQ_REGISTER   = 2'd0;
	localparam logic [1:0] REQ_UNREGISTER = 2'd1;
	localparam logic [1:0] REQ_CLEAR      = 2'd2;

	typedef enum logic [2:0] {
		ST_DONE    = 3'd0,
		ST_ZERO    = 3'd1,
		ST_DUP     = 3'd2,
		ST_UNKNOWN = 3'd3,
		ST_FULL    = 3'd4
	} status_t;

endpackage

// File: sv/optrk_id_ram.sv
// Identifier store for the tracker: one write port, one read port, registered read data.
// Takes its default sizes from optrk_pkg.
module optrk_id_ram #(
	parameter int unsigned DEPTH = optrk_pkg::TABLE_DEPTH_DEF,
	parameter int unsigned WIDTH = optrk_pkg::ID_WIDTH_DEF,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: sv/outstanding_packet_id_tracker_top.sv
// Outstanding packet identifier tracker: each request registers, unregisters or clears
// identifiers held in a TABLE_DEPTH-entry table and returns one result with a status, the
// count still held and an all-sent flag. Every request walks the whole table through the
// identifier RAM, one slot per cycle, before the next input transfer is taken; the result
// transfer is buffered in an output register, so the next request may be accepted while it
// waits. A register goes into the lowest free slot. There is no clearing pass after reset:
// slot valid bits are flip-flops that reset clears at once.
// Depends on optrk_pkg and optrk_id_ram.
module outstanding_packet_id_tracker_top #(
	parameter int unsigned TABLE_DEPTH = optrk_pkg::TABLE_DEPTH_DEF,
	parameter int unsigned ID_WIDTH    = optrk_pkg::ID_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     req_type,
	input  logic [ID_WIDTH-1:0]            packet_id,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [2:0]                     status,
	output logic [optrk_pkg::REM_W-1:0]    remaining,
	output logic                           all_sent
);

	localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned REM_W = optrk_pkg::REM_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	state_t                    state_q;
	logic [1:0]                req_q;
	logic [ID_WIDTH-1:0]       id_q;
	logic [CNT_W-1:0]          issue_q;
	logic                      rd_vld_s1;
	logic [IDX_W-1:0]          rd_idx_s1;
	logic [ID_WIDTH-1:0]       rd_data_s1;
	logic                      found_q;
	logic [IDX_W-1:0]          hit_idx_q;
	logic                      free_q;
	logic [IDX_W-1:0]          free_idx_q;
	logic [TABLE_DEPTH-1:0]    slot_valid_q;
	logic [CNT_W-1:0]          held_count_q;
	optrk_pkg::status_t        res_status_q;
	optrk_pkg::status_t        status_q;
	logic [REM_W-1:0]          remaining_q;
	logic                      all_sent_q;
	logic                      out_valid_q;

	logic                      decide;
	logic                      slot_hit;
	logic                      slot_free;
	optrk_pkg::status_t        dec_status;
	logic                      dec_set;
	logic                      dec_clr;
	logic                      dec_clr_all;
	logic [CNT_W-1:0]          cnt_next;
	logic [CNT_W+REM_W-1:0]    cnt_ext;

	optrk_id_ram #(
		.DEPTH (TABLE_DEPTH),
		.WIDTH (ID_WIDTH)
	) u_id_ram (
		.clk   (clk),
		.we    (decide && dec_set),
		.waddr (free_idx_q),
		.wdata (id_q),
		.raddr (issue_q[IDX_W-1:0]),
		.rdata (rd_data_s1)
	);

	// The decision is taken once the last read has been compared.
	assign decide = (state_q == S_SCAN) && (issue_q == CNT_W'(TABLE_DEPTH)) && !rd_vld_s1;

	assign slot_hit  = slot_valid_q[rd_idx_s1] && (rd_data_s1 == id_q);
	assign slot_free = !slot_valid_q[rd_idx_s1];

	always_comb begin
		dec_status  = optrk_pkg::ST_DONE;
		dec_set     = 1'b0;
		dec_clr     = 1'b0;
		dec_clr_all = 1'b0;
		cnt_next    = held_count_q;
		case (req_q)
			optrk_pkg::REQ_REGISTER: begin
				if (id_q == '0) begin
					dec_status = optrk_pkg::ST_ZERO;
				end else if (found_q) begin
					dec_status = optrk_pkg::ST_DUP;
				end else if (!free_q) begin
					dec_status = optrk_pkg::ST_FULL;
				end else begin
					dec_set  = 1'b1;
					cnt_next = held_count_q + CNT_W'(1);
				end
			end
			optrk_pkg::REQ_UNREGISTER: begin
				if (!found_q) begin
					dec_status = optrk_pkg::ST_UNKNOWN;
				end else begin
					dec_clr  = 1'b1;
					cnt_next = held_count_q - CNT_W'(1);
				end
			end
			optrk_pkg::REQ_CLEAR: begin
				dec_clr_all = 1'b1;
				cnt_next    = '0;
			end
			default: begin
			end
		endcase
	end

	assign cnt_ext = {{REM_W{1'b0}}, held_count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			req_q        <= '0;
			id_q         <= '0;
			issue_q      <= '0;
			rd_vld_s1    <= 1'b0;
			rd_idx_s1    <= '0;
			found_q      <= 1'b0;
			hit_idx_q    <= '0;
			free_q       <= 1'b0;
			free_idx_q   <= '0;
			slot_valid_q <= '0;
			held_count_q <= '0;
			res_status_q <= optrk_pkg::ST_DONE;
			status_q     <= optrk_pkg::ST_DONE;
			remaining_q  <= '0;
			all_sent_q   <= 1'b1;
			out_valid_q  <= 1'b0;
		end else begin
			// In the result stage a new result takes the register in the same cycle.
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q   <= req_type;
						id_q    <= packet_id;
						issue_q <= '0;
						found_q <= 1'b0;
						free_q  <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					rd_vld_s1 <= (issue_q != CNT_W'(TABLE_DEPTH));
					rd_idx_s1 <= issue_q[IDX_W-1:0];
					if (issue_q != CNT_W'(TABLE_DEPTH)) begin
						issue_q <= issue_q + CNT_W'(1);
					end
					// Keep the first match and the lowest free slot seen by the walk.
					if (rd_vld_s1) begin
						if (slot_hit && !found_q) begin
							found_q   <= 1'b1;
							hit_idx_q <= rd_idx_s1;
						end
						if (slot_free && !free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= rd_idx_s1;
						end
					end
					if (decide) begin
						if (dec_clr_all) begin
							slot_valid_q <= '0;
						end else if (dec_set) begin
							slot_valid_q[free_idx_q] <= 1'b1;
						end else if (dec_clr) begin
							slot_valid_q[hit_idx_q] <= 1'b0;
						end
						held_count_q <= cnt_next;
						res_status_q <= dec_status;
						state_q      <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						status_q    <= res_status_q;
						remaining_q <= cnt_ext[REM_W-1:0];
						all_sent_q  <= (held_count_q == '0);
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign remaining = remaining_q;
	assign all_sent  = all_sent_q;

`ifndef ASSERT_OFF
	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(slot_valid_q) == int'(held_count_q))
		else $error("held count differs from the number of valid slots");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_count_q <= CNT_W'(TABLE_DEPTH))
		else $error("held count exceeds the table depth");

	a_all_sent_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (all_sent_q == (remaining_q == '0)) || (TABLE_DEPTH > 31))
		else $error("all-sent flag disagrees with the remaining count");

	a_scan_before_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |-> $past(state_q == S_SCAN) || $past(state_q == S_DONE))
		else $error("result stage entered without a table walk");
`endif

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for outstanding_packet_id_tracker_top: a directed table, then random
// register, unregister, clear and unused-type traffic, each result checked against a local table model.
// Depends on optrk_pkg and the tracker RTL.
module tb_top;

	import optrk_pkg::*;

	localparam int unsigned DEPTH        = TABLE_DEPTH_DEF;
	localparam int unsigned ID_W         = ID_WIDTH_DEF;
	localparam int unsigned DRAIN_CYCLES = 3 * (DEPTH + 4);
	localparam int unsigned RANDOM_ITEMS = 500;
	localparam logic [1:0]  REQ_UNUSED   = 2'd3;

	typedef struct {
		status_t            st;
		logic [REM_W-1:0]   remaining;
		logic               all_sent;
	} outcome_t;

	typedef struct {
		logic [1:0]         req;
		logic [ID_W-1:0]    id;
		bit                 typed;
		outcome_t           want;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [1:0]            req_type = '0;
	logic [ID_W-1:0]       packet_id = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [2:0]            status;
	logic [REM_W-1:0]      remaining;
	logic                  all_sent;

	// Local copy of the identifier table.
	logic [ID_W-1:0]       held_ids [DEPTH];
	bit                    held_vld [DEPTH];
	int unsigned           held_cnt;

	outcome_t              awaited_outcomes [$];
	stim_row_t             directed_rows [$];
	int unsigned           errors;
	bit                    steady;

	outstanding_packet_id_tracker_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.packet_id (packet_id),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.remaining (remaining),
		.all_sent  (all_sent)
	);

	always #5 clk = ~clk;

	initial begin
		#2_000_000;
		$display("outstanding_packet_id_tracker_top verification failed");
		$finish;
	end

	// Updates the table copy for one request and returns the result it must produce.
	function automatic outcome_t apply_request(logic [1:0] req, logic [ID_W-1:0] id);
		outcome_t res;
		int hit;
		int free;
		hit = -1;
		free = -1;
		for (int s = 0; s < DEPTH; s++) begin
			if (held_vld[s] && held_ids[s] == id && hit < 0)
				hit = s;
			if (!held_vld[s] && free < 0)
				free = s;
		end
		res.st = ST_DONE;
		case (req)
			REQ_REGISTER: begin
				// Zero beats duplicate, and duplicate beats full.
				if (id == '0) begin
					res.st = ST_ZERO;
				end else if (hit >= 0) begin
					res.st = ST_DUP;
				end else if (free < 0) begin
					res.st = ST_FULL;
				end else begin
					held_ids[free] = id;
					held_vld[free] = 1'b1;
					held_cnt++;
				end
			end
			REQ_UNREGISTER: begin
				if (hit < 0) begin
					res.st = ST_UNKNOWN;
				end else begin
					held_vld[hit] = 1'b0;
					held_cnt--;
				end
			end
			REQ_CLEAR: begin
				for (int s = 0; s < DEPTH; s++)
					held_vld[s] = 1'b0;
				held_cnt = 0;
			end
			default: begin
			end
		endcase
		res.remaining = REM_W'(held_cnt);
		res.all_sent = (held_cnt == 0);
		return res;
	endfunction

	function automatic int unsigned draw_gap();
		return steady ? 0 : $urandom_range(0, 4);
	endfunction

	function automatic void add_row(logic [1:0] req, logic [ID_W-1:0] id, bit typed,
			status_t st, logic [REM_W-1:0] rem, logic all);
		stim_row_t row;
		row.req = req;
		row.id = id;
		row.typed = typed;
		row.want.st = st;
		row.want.remaining = rem;
		row.want.all_sent = all;
		directed_rows.push_back(row);
	endfunction

	// Presents one request and returns, at the edge of its transfer, the predicted result.
	task automatic send_request(input logic [1:0] req, input logic [ID_W-1:0] id,
			output outcome_t predicted);
		int unsigned gap;
		gap = draw_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		packet_id <= id;
		do @(posedge clk); while (!(in_valid && in_ready));
		predicted = apply_request(req, id);
	endtask

	// Result side: ready is held off for a random number of cycles before each transfer.
	initial begin : result_sink
		int unsigned stall;
		@(posedge arst_n);
		forever begin
			stall = draw_gap();
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	always @(posedge clk) begin : result_check
		outcome_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_outcomes.size() == 0) begin
				$error("result transfer with no request outstanding: status %0d remaining %0d",
					status, remaining);
				errors++;
			end else begin
				want = awaited_outcomes.pop_front();
				if (status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, status);
					errors++;
				end
				if (remaining !== want.remaining) begin
					$error("remaining: expected %0d, got %0d", want.remaining, remaining);
					errors++;
				end
				if (all_sent !== want.all_sent) begin
					$error("all_sent: expected %0d, got %0d", want.all_sent, all_sent);
					errors++;
				end
			end
		end
	end

	initial begin : stimulus
		outcome_t predicted;
		logic [1:0] req;
		logic [ID_W-1:0] id;
		int unsigned pick;
		logic [ID_W-1:0] live_ids [$];

		// Empty table: refusals, the unused request type, then a duplicate.
		add_row(REQ_REGISTER, '0, 1'b1, ST_ZERO, 5'd0, 1'b1);
		add_row(REQ_UNREGISTER, '0, 1'b1, ST_UNKNOWN, 5'd0, 1'b1);
		add_row(REQ_UNUSED, '1, 1'b1, ST_DONE, 5'd0, 1'b1);
		add_row(REQ_REGISTER, '1, 1'b1, ST_DONE, 5'd1, 1'b0);
		add_row(REQ_REGISTER, '1, 1'b1, ST_DUP, 5'd1, 1'b0);
		// Fill every remaining slot.
		for (int k = 0; k < DEPTH - 1; k++)
			add_row(REQ_REGISTER, ID_W'(16'h0001 + k * 16'h1111), 1'b0, ST_DONE, '0, 1'b0);
		add_row(REQ_REGISTER, 16'h5555, 1'b1, ST_FULL, 5'd16, 1'b0);
		add_row(REQ_REGISTER, '0, 1'b1, ST_ZERO, 5'd16, 1'b0);
		add_row(REQ_REGISTER, '1, 1'b1, ST_DUP, 5'd16, 1'b0);
		add_row(REQ_UNREGISTER, 16'hAAAA, 1'b1, ST_UNKNOWN, 5'd16, 1'b0);
		add_row(REQ_UNREGISTER, 16'h1112, 1'b0, ST_DONE, '0, 1'b0);
		add_row(REQ_REGISTER, 16'h5555, 1'b0, ST_DONE, '0, 1'b0);
		add_row(REQ_CLEAR, 16'h1234, 1'b1, ST_DONE, 5'd0, 1'b1);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[r]) begin
			send_request(directed_rows[r].req, directed_rows[r].id, predicted);
			awaited_outcomes.push_back(directed_rows[r].typed ? directed_rows[r].want : predicted);
		end

		// A small identifier pool keeps duplicates and a full table common.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0)
				steady = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				req = REQ_REGISTER;
			end else if (pick < 96) begin
				req = REQ_UNREGISTER;
			end else if (pick < 98) begin
				req = REQ_CLEAR;
			end else begin
				req = REQ_UNUSED;
			end
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				id = '0;
			end else if (pick < 7) begin
				id = ID_W'($urandom_range(1, 24));
			end else begin
				id = ID_W'($urandom_range(0, 16'hFFFF));
			end
			if (req == REQ_UNREGISTER && held_cnt != 0 && $urandom_range(0, 9) < 6) begin
				live_ids.delete();
				for (int s = 0; s < DEPTH; s++)
					if (held_vld[s])
						live_ids.push_back(held_ids[s]);
				id = live_ids[$urandom_range(0, live_ids.size() - 1)];
			end
			send_request(req, id, predicted);
			awaited_outcomes.push_back(predicted);
		end
		in_valid <= 1'b0;

		while (awaited_outcomes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("outstanding_packet_id_tracker_top verification clean");
		else
			$display("outstanding_packet_id_tracker_top verification failed");
		$finish;
	end

endmodule
